>>> rtl/kt_pkg.sv
`timescale 1ns / 1ps

package kt_pkg;

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [1:0] KIND_DELETE  = 2'd2;
  localparam logic [1:0] KIND_COMPACT = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [31:0]        info;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  position;
    logic [31:0] info_out;
    logic [4:0]  used_count;
  } rsp_t;

endpackage

>>> rtl/keyed_table_with_lazy_delete.sv
`timescale 1ns / 1ps

// Unordered key table with lazy delete. Entries (busy flag, key, info) live in one
// synchronous memory with one read and one write port. One request is worked at a
// time: insert, lookup and delete scan slots 0 to used_count-1 one slot per cycle
// through the read port, stopping at the first busy match; compact streams the same
// slots and writes each busy entry to the next free low slot. An insert into a full
// table fails without a scan. The next request is taken as soon as the result sits
// in the output register. No memory clearing is needed after reset.
module keyed_table_with_lazy_delete #(
  parameter int CAPACITY   = 16,
  parameter int INFO_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  kt_pkg::req_t in_req,
  output logic         out_valid,
  input  logic         out_ready,
  output kt_pkg::rsp_t out_rsp,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata
);

  import kt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (INFO_WIDTH < 32) ? INFO_WIDTH : 32;
  localparam int DW = 1 + 32 + SW;
  localparam int MW = (CW > 5) ? CW : 5;
  localparam int PW = (AW > 4) ? AW : 4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [4:0]    limit_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] rd_i_r, rd_i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          rd_v_r;
  logic [AW-1:0] rd_idx_r;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [SW-1:0] info_r, info_nxt;
  logic          status_r, status_nxt;
  logic [3:0]    pos_r, pos_nxt;
  logic [31:0]   info_o_r, info_o_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_r, out_nxt;

  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rdata;
  logic          hit;
  logic [MW-1:0] used_ext;
  logic [MW-1:0] lim_ext;
  logic [MW-1:0] cap_m;
  logic [MW-1:0] limit_eff;
  logic [PW-1:0] pos_ext;

  kt_entry_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW),
    .DW   (DW)
  ) u_mem (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_i_r[AW-1:0]),
    .rdata(rdata)
  );

  assign used_ext  = MW'(used_r);
  assign lim_ext   = MW'(limit_r);
  assign cap_m     = MW'(CAPACITY);
  assign limit_eff = (lim_ext > cap_m) ? cap_m : lim_ext;
  assign pos_ext   = PW'(rd_idx_r);
  assign hit       = rd_v_r && rdata[DW-1] && (rdata[DW-2:SW] == key_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    rd_i_nxt      = rd_i_r;
    j_nxt         = j_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    info_nxt      = info_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    info_o_nxt    = info_o_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_req.kind;
          key_nxt    = in_req.key;
          info_nxt   = in_req.info[SW-1:0];
          rd_i_nxt   = '0;
          j_nxt      = '0;
          status_nxt = STATUS_OK;
          pos_nxt    = '0;
          info_o_nxt = '0;
          if (in_req.kind == KIND_INSERT && used_ext >= limit_eff) begin
            status_nxt = STATUS_FAIL;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = (rd_i_r < used_r);
        if (rd_en) begin
          rd_i_nxt = rd_i_r + CW'(1);
        end
        if (rd_v_r) begin
          if (kind_r == KIND_COMPACT) begin
            if (rdata[DW-1]) begin
              wr_en   = 1'b1;
              wr_addr = j_r[AW-1:0];
              wr_data = rdata;
              j_nxt   = j_r + CW'(1);
            end
          end else if (hit) begin
            state_nxt = ST_DONE;
            unique case (kind_r)
              KIND_INSERT: begin
                status_nxt = STATUS_FAIL;
              end
              KIND_LOOKUP: begin
                pos_nxt    = pos_ext[3:0];
                info_o_nxt = 32'(rdata[SW-1:0]);
              end
              KIND_DELETE: begin
                pos_nxt = pos_ext[3:0];
                wr_en   = 1'b1;
                wr_addr = rd_idx_r;
                wr_data = {1'b0, rdata[DW-2:0]};
              end
              KIND_COMPACT: begin
              end
            endcase
          end
        end else if (rd_i_r == used_r) begin
          state_nxt = ST_DONE;
          unique case (kind_r)
            KIND_INSERT: begin
              wr_en    = 1'b1;
              wr_addr  = used_r[AW-1:0];
              wr_data  = {1'b1, key_r, info_r};
              used_nxt = used_r + CW'(1);
            end
            KIND_LOOKUP, KIND_DELETE: begin
              status_nxt = STATUS_FAIL;
            end
            KIND_COMPACT: begin
              used_nxt = j_r;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.position    = pos_r;
          out_nxt.info_out    = info_o_r;
          out_nxt.used_count  = used_ext[4:0];
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      limit_r     <= LIMIT_RESET;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_v_r      <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_i_r   <= rd_i_nxt;
    j_r      <= j_nxt;
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    info_r   <= info_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    info_o_r <= info_o_nxt;
    out_r    <= out_nxt;
    if (rd_en) begin
      rd_idx_r <= rd_i_r[AW-1:0];
    end
  end

endmodule

>>> rtl/kt_entry_mem.sv
`timescale 1ns / 1ps

module kt_entry_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 65
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/kt_checker.sv
`timescale 1ns / 1ps

module kt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input kt_pkg::req_t in_req,
  input logic         out_valid,
  input logic         out_ready,
  input kt_pkg::rsp_t out_rsp
);

  import kt_pkg::*;

  // hold a waiting request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_req))
    else $error("waiting request changed");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // failures carry no position or info
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == STATUS_FAIL |->
      out_rsp.position == 4'd0 && out_rsp.info_out == 32'd0)
    else $error("failure with nonzero fields");

endmodule

bind keyed_table_with_lazy_delete kt_checker u_kt_checker (.*);
